/* rtl/ptg_pkg.sv */
// Shared types, constants and waveform tables for the poly tone generator.
`default_nettype none

package ptg_pkg;

   localparam int NUM_CHAN = 2;

   // payload widths
   localparam int CMD_W    = 1;
   localparam int SEL_W    = 3;
   localparam int DATA_W   = 8;
   localparam int SAMPLE_W = 7;

   // per-channel state widths
   localparam int LEVEL_W  = 6;
   localparam int RELOAD_W = 7;
   localparam int CTRL_W   = 4;
   localparam int FREQ_W   = 5;
   localparam int VOL_W    = 6;
   localparam int P4_W     = 4;
   localparam int P5_W     = 5;
   localparam int P9_W     = 9;

   localparam int POLY4_LEN = 15;
   localparam int POLY5_LEN = 31;
   localparam int POLY9_LEN = 511;

   // controls above this value run the divider three times slower
   localparam logic [CTRL_W-1:0] CTRL_TRIPLE_ABOVE = 4'd11;
   // the only control that uses the 9-bit polynomial
   localparam logic [CTRL_W-1:0] CTRL_POLY9 = 4'd8;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [SEL_W-1:0] {
      SEL_CTRL0 = 3'd0,
      SEL_CTRL1 = 3'd1,
      SEL_FREQ0 = 3'd2,
      SEL_FREQ1 = 3'd3,
      SEL_VOL0  = 3'd4,
      SEL_VOL1  = 3'd5
   } sel_type;

   typedef enum logic [1:0] {
      FLD_CTRL,
      FLD_FREQ,
      FLD_VOL
   } field_type;

   // one operation handed to a channel
   typedef struct packed {
      logic              tick;
      logic              wr;
      field_type         field;
      logic [DATA_W-1:0] data;
   } chan_op_type;

   // waveform tables, index 0 leftmost
   localparam logic [0:POLY4_LEN-1] POLY4 = 15'b1101110_00010100;
   localparam logic [0:POLY5_LEN-1] POLY5 = 31'b00101100_11111000_11011101_0100001;
   localparam logic [0:POLY5_LEN-1] DIV31 = 31'b10000000_00000000_00100000_0000000;
   localparam logic [0:POLY9_LEN-1] POLY9 = {
      64'b00101000_10000000_10111001_01001111_10011011_01011101_10010011_11010000,
      64'b11011000_10001111_01011010_10000110_10100010_10001110_01101100_11111001,
      64'b10001101_00011001_11100100_01110011_01011011_01001001_11111011_11011000,
      64'b01111100_01000010_00101011_00001011_11010001_10001110_11101000_00000101,
      64'b00100001_11000111_00110010_01011000_01000100_01011110_00111000_10011110,
      64'b11111110_11111101_10101111_00101011_10000011_01100010_10100001_01110000,
      64'b10010100_01011100_11111110_00001001_10100100_01001010_00110100_00011110,
      63'b01001011_11111010_01000110_11100010_10010101_01110010_11001111_1000110
   };

endpackage

`default_nettype wire

/* rtl/ptg_if.sv */
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface ptg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [ptg_pkg::SEL_W-1:0]     reg_select;
   logic [ptg_pkg::DATA_W-1:0]    write_data;

   modport source (output valid, cmd, reg_select, write_data, input ready);
   modport sink   (input valid, cmd, reg_select, write_data, output ready);
endinterface

interface ptg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptg_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

/* rtl/ptg_chan.sv */
// One sound channel: registers, divider, polynomial counters and output level.
`default_nettype none

module ptg_chan (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ptg_pkg::chan_op_type         op,
   output logic [ptg_pkg::LEVEL_W-1:0]       level_next
);

   localparam int LW = ptg_pkg::LEVEL_W;
   localparam int RW = ptg_pkg::RELOAD_W;
   localparam int CW = ptg_pkg::CTRL_W;
   localparam int FW = ptg_pkg::FREQ_W;
   localparam int VW = ptg_pkg::VOL_W;
   localparam int P4W = ptg_pkg::P4_W;
   localparam int P5W = ptg_pkg::P5_W;
   localparam int P9W = ptg_pkg::P9_W;

   logic [LW-1:0]  level_ff,  level_in;
   logic [RW-1:0]  reload_ff, reload_in;
   logic [RW-1:0]  count_ff,  count_in;
   logic [CW-1:0]  ctrl_ff,   ctrl_in;
   logic [FW-1:0]  freq_ff,   freq_in;
   logic [VW-1:0]  vol_ff,    vol_in;
   logic [P4W-1:0] pos4_ff,   pos4_in;
   logic [P5W-1:0] pos5_ff,   pos5_in;
   logic [P9W-1:0] pos9_ff,   pos9_in;

   logic [CW-1:0]  ctrl_new;
   logic [FW-1:0]  freq_new;
   logic [VW-1:0]  vol_new;
   logic [RW-1:0]  rl_base;
   logic [RW-1:0]  rl_calc;
   logic [P4W-1:0] p4_next;
   logic [P5W-1:0] p5_next;
   logic [P9W-1:0] p9_next;
   logic           act;

   always_comb begin
      ctrl_new = ctrl_ff;
      freq_new = freq_ff;
      vol_new  = vol_ff;
      if (op.wr) begin
         case (op.field)
            ptg_pkg::FLD_CTRL: ctrl_new = op.data[CW-1:0];
            ptg_pkg::FLD_FREQ: freq_new = op.data[FW-1:0];
            ptg_pkg::FLD_VOL:  vol_new  = {op.data[VW-3:0], 2'b00};
            default: ;
         endcase
      end

      rl_base = RW'(freq_new) + RW'(1);
      if (ctrl_new == '0) begin
         rl_calc = '0;
      end else if (ctrl_new > ptg_pkg::CTRL_TRIPLE_ABOVE) begin
         rl_calc = rl_base + {rl_base[RW-2:0], 1'b0};
      end else begin
         rl_calc = rl_base;
      end

      p4_next = (pos4_ff == P4W'(ptg_pkg::POLY4_LEN - 1)) ? '0 : pos4_ff + P4W'(1);
      p5_next = (pos5_ff == P5W'(ptg_pkg::POLY5_LEN - 1)) ? '0 : pos5_ff + P5W'(1);
      p9_next = (pos9_ff == P9W'(ptg_pkg::POLY9_LEN - 1)) ? '0 : pos9_ff + P9W'(1);

      act = !ctrl_ff[1] ||
            (!ctrl_ff[0] && ptg_pkg::DIV31[p5_next]) ||
            ( ctrl_ff[0] && ptg_pkg::POLY5[p5_next]);

      level_in  = level_ff;
      reload_in = reload_ff;
      count_in  = count_ff;
      ctrl_in   = ctrl_ff;
      freq_in   = freq_ff;
      vol_in    = vol_ff;
      pos4_in   = pos4_ff;
      pos5_in   = pos5_ff;
      pos9_in   = pos9_ff;

      if (op.wr) begin
         ctrl_in = ctrl_new;
         freq_in = freq_new;
         vol_in  = vol_new;
         if (ctrl_new == '0) begin
            level_in = vol_new;
         end
         if (rl_calc != reload_ff) begin
            reload_in = rl_calc;
            if (count_ff == '0 || rl_calc == '0) begin
               count_in = rl_calc;
            end
         end
      end else if (op.tick) begin
         if (count_ff > RW'(1)) begin
            count_in = count_ff - RW'(1);
         end else if (count_ff == RW'(1)) begin
            count_in = reload_ff;
            pos5_in  = p5_next;
            if (act) begin
               if (ctrl_ff[2]) begin
                  // square wave: toggle between silence and volume
                  level_in = (level_ff == '0) ? vol_ff : '0;
               end else if (ctrl_ff[3]) begin
                  if (ctrl_ff == ptg_pkg::CTRL_POLY9) begin
                     pos9_in  = p9_next;
                     level_in = ptg_pkg::POLY9[p9_next] ? vol_ff : '0;
                  end else begin
                     level_in = ptg_pkg::POLY5[p5_next] ? vol_ff : '0;
                  end
               end else begin
                  pos4_in  = p4_next;
                  level_in = ptg_pkg::POLY4[p4_next] ? vol_ff : '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         reload_ff <= '0;
         count_ff  <= '0;
         ctrl_ff   <= '0;
         freq_ff   <= '0;
         vol_ff    <= '0;
         pos4_ff   <= '0;
         pos5_ff   <= '0;
         pos9_ff   <= '0;
      end else begin
         level_ff  <= level_in;
         reload_ff <= reload_in;
         count_ff  <= count_in;
         ctrl_ff   <= ctrl_in;
         freq_ff   <= freq_in;
         vol_ff    <= vol_in;
         pos4_ff   <= pos4_in;
         pos5_ff   <= pos5_in;
         pos9_ff   <= pos9_in;
      end
   end

   assign level_next = level_in;

   a_ctrl_off_no_reload: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff == '0) |-> (reload_ff == '0))
      else $error("channel disabled but reload nonzero");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= RW'(96)) && (reload_ff <= RW'(96)))
      else $error("divider count or reload out of range");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (pos4_ff < P4W'(ptg_pkg::POLY4_LEN)) && (pos5_ff < P5W'(ptg_pkg::POLY5_LEN)) &&
      (pos9_ff < P9W'(ptg_pkg::POLY9_LEN)))
      else $error("polynomial position out of range");

endmodule

`default_nettype wire

/* rtl/two_channel_poly_tone_generator.sv */
// Top level: input register, command decode, two channels and the sample register.
//
//   channel   dir   payload                          transfer when
//   req_if    in    cmd, reg_select, write_data      valid && ready
//   rsp_if    out   sample (one per tick command)     valid && ready
//
// One item per cycle sustained while no sample waits unaccepted. A transfer lands
// in the input register; when it moves on, both channels update and a tick's sum
// loads the sample register, which drives rsp valid. Writes give no sample.
// Sync reset clears all channel state.
// While a sample waits unaccepted, the input register still takes one item,
// then ready drops until the sample is taken.
`default_nettype none

module two_channel_poly_tone_generator (
   input  wire logic       clock,
   input  wire logic       reset,
   ptg_req_if.sink         req_if,
   ptg_rsp_if.source       rsp_if
);

   localparam int NC = ptg_pkg::NUM_CHAN;
   localparam int SW = ptg_pkg::SAMPLE_W;

   logic                          in_vld_ff,  in_vld_in;
   logic                          in_cmd_ff,  in_cmd_in;
   logic [ptg_pkg::SEL_W-1:0]     in_sel_ff,  in_sel_in;
   logic [ptg_pkg::DATA_W-1:0]    in_data_ff, in_data_in;
   logic                          out_vld_ff, out_vld_in;
   logic [SW-1:0]                 out_sample_ff, out_sample_in;

   logic                          advance;
   logic                          fire;
   logic                          is_tick;
   logic                          sel_ok;
   ptg_pkg::field_type            field;
   ptg_pkg::chan_op_type          chan_op [NC];
   logic [ptg_pkg::LEVEL_W-1:0]   level_next [NC];

   assign advance      = !out_vld_ff || rsp_if.ready;
   assign req_if.ready = !in_vld_ff || advance;
   assign fire         = in_vld_ff && advance;
   assign is_tick      = (in_cmd_ff == ptg_pkg::CMD_TICK);

   always_comb begin
      sel_ok = 1'b1;
      field  = ptg_pkg::FLD_CTRL;
      unique case (in_sel_ff) inside
         ptg_pkg::SEL_CTRL0, ptg_pkg::SEL_CTRL1: field = ptg_pkg::FLD_CTRL;
         ptg_pkg::SEL_FREQ0, ptg_pkg::SEL_FREQ1: field = ptg_pkg::FLD_FREQ;
         ptg_pkg::SEL_VOL0,  ptg_pkg::SEL_VOL1:  field = ptg_pkg::FLD_VOL;
         default: sel_ok = 1'b0;
      endcase
   end

   for (genvar c = 0; c < NC; c++) begin : g_chan
      always_comb begin
         chan_op[c].tick  = fire && is_tick;
         chan_op[c].wr    = fire && !is_tick && sel_ok && (in_sel_ff[0] == 1'(c));
         chan_op[c].field = field;
         chan_op[c].data  = in_data_ff;
      end

      ptg_chan u_chan (
         .clock      (clock),
         .reset      (reset),
         .op         (chan_op[c]),
         .level_next (level_next[c])
      );
   end

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_cmd_in  = in_cmd_ff;
      in_sel_in  = in_sel_ff;
      in_data_in = in_data_ff;
      if (req_if.ready) begin
         in_vld_in  = req_if.valid;
         in_cmd_in  = req_if.cmd;
         in_sel_in  = req_if.reg_select;
         in_data_in = req_if.write_data;
      end

      out_vld_in    = out_vld_ff;
      out_sample_in = out_sample_ff;
      if (advance) begin
         out_vld_in    = fire && is_tick;
         out_sample_in = SW'(level_next[0]) + SW'(level_next[1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_cmd_ff     <= in_cmd_in;
      in_sel_ff     <= in_sel_in;
      in_data_ff    <= in_data_in;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_if.valid  = out_vld_ff;
   assign rsp_if.sample = out_sample_ff;

   a_tick_gives_sample: assert property (@(posedge clock) disable iff (reset)
      (fire && is_tick) |=> out_vld_ff)
      else $error("tick transfer produced no sample");

   a_sample_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(fire && is_tick))
      else $error("sample shown without a tick");

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_sample_ff <= SW'(120)))
      else $error("sample out of range");

endmodule

`default_nettype wire

/* bench/two_channel_poly_tone_generator_tb.sv */
// Self-checking bench for the two-channel poly tone generator: directed and random writes and ticks, sample scoreboard.
`default_nettype none

module two_channel_poly_tone_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;

   // selects with no register behind them
   localparam logic [ptg_pkg::SEL_W-1:0] SEL_SPARE6 = 3'd6;
   localparam logic [ptg_pkg::SEL_W-1:0] SEL_SPARE7 = 3'd7;

   class tone_checker;
      logic [ptg_pkg::LEVEL_W-1:0]  level  [ptg_pkg::NUM_CHAN];
      logic [ptg_pkg::RELOAD_W-1:0] reload [ptg_pkg::NUM_CHAN];
      logic [ptg_pkg::RELOAD_W-1:0] count  [ptg_pkg::NUM_CHAN];
      logic [ptg_pkg::CTRL_W-1:0]   ctrl   [ptg_pkg::NUM_CHAN];
      logic [ptg_pkg::FREQ_W-1:0]   freq   [ptg_pkg::NUM_CHAN];
      logic [ptg_pkg::VOL_W-1:0]    vol    [ptg_pkg::NUM_CHAN];
      int                           p4     [ptg_pkg::NUM_CHAN];
      int                           p5     [ptg_pkg::NUM_CHAN];
      int                           p9     [ptg_pkg::NUM_CHAN];
      logic [ptg_pkg::SAMPLE_W-1:0] pending_samples [$];
      int                           errors;
      int                           n_checked;

      function new();
         for (int c = 0; c < ptg_pkg::NUM_CHAN; c++) begin
            level[c]  = '0;
            reload[c] = '0;
            count[c]  = '0;
            ctrl[c]   = '0;
            freq[c]   = '0;
            vol[c]    = '0;
            p4[c]     = 0;
            p5[c]     = 0;
            p9[c]     = 0;
         end
         errors    = 0;
         n_checked = 0;
      endfunction

      // one audio tick for one channel: divider countdown and waveform step
      function void advance_channel(int c);
         logic act;
         if (count[c] > 1) begin
            count[c] = count[c] - 1'b1;
         end else if (count[c] == 1) begin
            count[c] = reload[c];
            p5[c] = (p5[c] + 1) % ptg_pkg::POLY5_LEN;
            act = !ctrl[c][1] || (!ctrl[c][0] && ptg_pkg::DIV31[p5[c]]) ||
                  (ctrl[c][0] && ptg_pkg::POLY5[p5[c]]);
            if (act) begin
               if (ctrl[c][2]) begin
                  level[c] = (level[c] == 0) ? vol[c] : '0;
               end else if (ctrl[c][3]) begin
                  if (ctrl[c] == ptg_pkg::CTRL_POLY9) begin
                     p9[c] = (p9[c] + 1) % ptg_pkg::POLY9_LEN;
                     level[c] = ptg_pkg::POLY9[p9[c]] ? vol[c] : '0;
                  end else begin
                     level[c] = ptg_pkg::POLY5[p5[c]] ? vol[c] : '0;
                  end
               end else begin
                  p4[c] = (p4[c] + 1) % ptg_pkg::POLY4_LEN;
                  level[c] = ptg_pkg::POLY4[p4[c]] ? vol[c] : '0;
               end
            end
         end
      endfunction

      function void take_request(logic cmd, logic [ptg_pkg::SEL_W-1:0] sel,
                                 logic [ptg_pkg::DATA_W-1:0] data);
         int                           c;
         logic [ptg_pkg::RELOAD_W-1:0] rl;
         if (cmd == ptg_pkg::CMD_WRITE) begin
            c = int'(sel[0]);
            case (sel) inside
               ptg_pkg::SEL_CTRL0, ptg_pkg::SEL_CTRL1:
                  ctrl[c] = data[ptg_pkg::CTRL_W-1:0];
               ptg_pkg::SEL_FREQ0, ptg_pkg::SEL_FREQ1:
                  freq[c] = data[ptg_pkg::FREQ_W-1:0];
               ptg_pkg::SEL_VOL0, ptg_pkg::SEL_VOL1:
                  vol[c]  = {data[3:0], 2'b00};
               default:
                  return;
            endcase
            if (ctrl[c] == 0) begin
               rl = '0;
               level[c] = vol[c];
            end else begin
               rl = {2'b00, freq[c]} + 1'b1;
               if (ctrl[c] > ptg_pkg::CTRL_TRIPLE_ABOVE)
                  rl = ptg_pkg::RELOAD_W'(rl * 3);
            end
            if (rl != reload[c]) begin
               reload[c] = rl;
               if (count[c] == 0 || rl == 0)
                  count[c] = rl;
            end
         end else begin
            advance_channel(0);
            advance_channel(1);
            pending_samples.push_back(ptg_pkg::SAMPLE_W'(level[0]) +
                                      ptg_pkg::SAMPLE_W'(level[1]));
         end
      endfunction

      function void match_sample(logic [ptg_pkg::SAMPLE_W-1:0] got);
         logic [ptg_pkg::SAMPLE_W-1:0] want;
         if (pending_samples.size() == 0) begin
            $error("sample: unexpected transfer, actual %0d", got);
            errors++;
         end else begin
            want = pending_samples.pop_front();
            n_checked++;
            if (got !== want) begin
               $error("sample: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   bit   hold_off_req;
   bit   hold_off_done;
   int   burst_left;
   int   n_ticks;
   int   n_writes;
   int   n_ignored;

   tone_checker chk;

   ptg_req_if req ();
   ptg_rsp_if rsp ();

   two_channel_poly_tone_generator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("two_channel_poly_tone_generator_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         chk.match_sample(rsp.sample);
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // receiver side: random ready with one long hold-off on request
   initial begin
      int n;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            n = pick_gap();
            rsp.ready <= 1'b0;
            repeat (n + 1) @(posedge clock);
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            rsp.ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // one transfer on the request side; valid stays high only when the next item follows without a gap
   task automatic offer(input logic cmd, input logic [ptg_pkg::SEL_W-1:0] sel,
                        input logic [ptg_pkg::DATA_W-1:0] data);
      int gap;
      req.valid      <= 1'b1;
      req.cmd        <= cmd;
      req.reg_select <= sel;
      req.write_data <= data;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      chk.take_request(cmd, sel, data);
      if (cmd == ptg_pkg::CMD_TICK)
         n_ticks++;
      else if (sel > ptg_pkg::SEL_VOL1)
         n_ignored++;
      else
         n_writes++;
      if (hold_off_req && !hold_off_done) begin
         gap = 0;
      end else if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 99) == 0)
            burst_left = $urandom_range(30, 80);
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic tick();
      offer(ptg_pkg::CMD_TICK, ptg_pkg::SEL_W'($urandom_range(0, 7)),
            ptg_pkg::DATA_W'($urandom_range(0, 255)));
   endtask

   task automatic write_reg(input logic [ptg_pkg::SEL_W-1:0] sel,
                            input logic [ptg_pkg::DATA_W-1:0] data);
      offer(ptg_pkg::CMD_WRITE, sel, data);
   endtask

   initial begin
      int unsigned                r;
      int                         counted;
      logic [ptg_pkg::SEL_W-1:0]  sel;
      logic [ptg_pkg::DATA_W-1:0] data;

      chk           = new();
      cycles        = 0;
      hold_off_req  = 1'b0;
      hold_off_done = 1'b0;
      burst_left    = 0;
      n_ticks       = 0;
      n_writes      = 0;
      n_ignored     = 0;
      reset          <= 1'b1;
      req.valid      <= 1'b0;
      req.cmd        <= ptg_pkg::CMD_TICK;
      req.reg_select <= '0;
      req.write_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset state, immediate level for control zero, spare selects,
      // square toggle (also with zero volume), poly9, triple divider, field extremes
      tick();
      write_reg(ptg_pkg::SEL_VOL0, 8'hFF);
      write_reg(ptg_pkg::SEL_VOL1, 8'hF0);
      tick();
      write_reg(SEL_SPARE6, 8'hFF);
      write_reg(SEL_SPARE7, 8'hAA);
      tick();
      write_reg(ptg_pkg::SEL_FREQ0, 8'h00);
      write_reg(ptg_pkg::SEL_CTRL0, 8'h04);
      tick();
      tick();
      tick();
      write_reg(ptg_pkg::SEL_FREQ1, 8'h00);
      write_reg(ptg_pkg::SEL_CTRL1, 8'h04);
      tick();
      tick();
      write_reg(ptg_pkg::SEL_CTRL0, ptg_pkg::DATA_W'(ptg_pkg::CTRL_POLY9));
      tick();
      write_reg(ptg_pkg::SEL_FREQ1, 8'hFF);
      write_reg(ptg_pkg::SEL_CTRL1, 8'h0C);
      write_reg(ptg_pkg::SEL_VOL1, 8'h0F);
      tick();
      write_reg(ptg_pkg::SEL_CTRL0, 8'hFF);
      tick();
      write_reg(ptg_pkg::SEL_CTRL0, 8'h00);
      tick();

      // random: mostly ticks, writes with small frequencies so waveforms advance
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted == 300)
            hold_off_req = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 75) begin
            tick();
            counted++;
         end else begin
            if ($urandom_range(0, 99) < 5)
               sel = ptg_pkg::SEL_W'($urandom_range(6, 7));
            else
               sel = ptg_pkg::SEL_W'($urandom_range(0, 5));
            data = ptg_pkg::DATA_W'($urandom_range(0, 255));
            if ((sel == ptg_pkg::SEL_FREQ0 || sel == ptg_pkg::SEL_FREQ1) &&
                $urandom_range(0, 99) < 70)
               data[ptg_pkg::FREQ_W-1:0] = ptg_pkg::FREQ_W'($urandom_range(0, 3));
            write_reg(sel, data);
            if (sel <= ptg_pkg::SEL_VOL1)
               counted++;
         end
      end
      req.valid <= 1'b0;

      while (chk.pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d ticks and %0d register writes (%0d to unused selects).",
               n_ticks, n_writes, n_ignored);
      $display("Compared %0d samples, including a %0d-cycle receiver hold-off.",
               chk.n_checked, HOLD_CYCLES);
      if (chk.errors == 0 && chk.pending_samples.size() == 0) begin
         $display("two_channel_poly_tone_generator_tb: clean");
      end else begin
         $display("two_channel_poly_tone_generator_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
